// ===== sv/fpn_pkg.sv =====
`default_nettype none
package fpn_pkg;

  localparam logic [3:0] CFG_OCTAVE_COUNT = 4'd0;
  localparam logic [3:0] CFG_PERSISTENCE  = 4'd1;

  localparam logic [3:0]  OCTAVE_COUNT_RESET = 4'd1;
  localparam logic [16:0] PERSISTENCE_RESET  = 17'd32768;
  localparam logic [16:0] AMP_ONE            = 17'd65536;
  localparam logic [15:0] NOISE_MAX          = 16'hFFFF;

  typedef logic [7:0] perm_t;

  localparam perm_t PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95, 8'd96,
    8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142,
    8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148, 8'd247,
    8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62, 8'd94, 8'd252, 8'd219, 8'd203,
    8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56,
    8'd87, 8'd174, 8'd20, 8'd125, 8'd136, 8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165,
    8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83,
    8'd111, 8'd229, 8'd122, 8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,
    8'd41, 8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25,
    8'd63, 8'd161, 8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208,
    8'd89, 8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159,
    8'd86, 8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217,
    8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126,
    8'd255, 8'd82, 8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58,
    8'd17, 8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213, 8'd119,
    8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153, 8'd101,
    8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98,
    8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193, 8'd238, 8'd210,
    8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51, 8'd145, 8'd235,
    8'd249, 8'd14, 8'd239, 8'd107, 8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199,
    8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121, 8'd50, 8'd45,
    8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93, 8'd222, 8'd114,
    8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195, 8'd78, 8'd66, 8'd215,
    8'd61, 8'd156, 8'd180
  };

  function automatic perm_t perm(input perm_t idx);
    return PERM_ROM[idx];
  endfunction

endpackage
`default_nettype wire

// ===== sv/fpn_core.sv =====
`default_nettype none
module fpn_core import fpn_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int AMP_W     = 17
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [31:0]                  in_x,
  input  wire logic [31:0]                  in_y,
  input  wire logic [31:0]                  in_z,
  input  wire logic [AMP_W-1:0]             in_amp,
  input  wire logic                         in_last,
  output logic                              out_valid,
  output logic [FRAC_BITS+AMP_W:0]          out_prod,
  output logic [AMP_W-1:0]                  out_amp,
  output logic                              out_last
);

  localparam int F  = FRAC_BITS;
  localparam int GW = F + 3;
  localparam int NS = 9;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
      input logic signed [GW-1:0] x, input logic signed [GW-1:0] y,
      input logic signed [GW-1:0] z);
    unique case (h)
      4'h0: return x + y;
      4'h1: return -x + y;
      4'h2: return x - y;
      4'h3: return -x - y;
      4'h4: return x + z;
      4'h5: return -x + z;
      4'h6: return x - z;
      4'h7: return -x - z;
      4'h8: return y + z;
      4'h9: return -y + z;
      4'hA: return y - z;
      4'hB: return -y - z;
      4'hC: return y + x;
      4'hD: return -y + z;
      4'hE: return y - x;
      default: return -y - z;
    endcase
  endfunction

  function automatic logic signed [GW-1:0] lerp(input logic signed [GW-1:0] a,
      input logic signed [GW-1:0] b, input logic [F:0] s);
    logic signed [GW:0]     diff;
    logic signed [GW+F+1:0] prod;
    diff = {b[GW-1], b} - {a[GW-1], a};
    prod = diff * $signed({1'b0, s});
    return a + GW'(prod >>> F);
  endfunction

  logic             vq    [1:NS];
  logic [AMP_W-1:0] ampq  [1:NS];
  logic             lastq [1:NS];

  logic [31:0]      cin [3];
  logic [2*F-1:0]   sq1 [3];
  logic [7:0]       ti1 [3];
  logic [F-1:0]     tf1 [3];
  logic [F-1:0]     t2_1 [3];
  perm_t            a1, b1;

  always_comb begin
    cin[0] = in_x;
    cin[1] = in_y;
    cin[2] = in_z;
    for (int j = 0; j < 3; j++) begin
      sq1[j] = (2*F)'(cin[j][F-1:0]) * (2*F)'(cin[j][F-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        ti1[j]  <= cin[j][F+7:F];
        tf1[j]  <= cin[j][F-1:0];
        t2_1[j] <= sq1[j][2*F-1:F];
      end
      a1 <= perm(cin[0][F+7:F]);
      b1 <= perm(cin[0][F+7:F] + 8'd1);
    end
  end

  logic [2*F-1:0] cube2 [3];
  logic [F+3:0]   p2c   [3];
  logic [F-1:0]   tf2 [3];
  logic [F-1:0]   t3_2 [3];
  logic [F+3:0]   p2 [3];
  logic [7:0]     zi2;
  perm_t          aa2, ab2, ba2, bb2;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cube2[j] = (2*F)'(t2_1[j]) * (2*F)'(tf1[j]);
      p2c[j]   = (F+4)'(t2_1[j]) * (F+4)'(6) - (F+4)'(tf1[j]) * (F+4)'(15)
                 + ((F+4)'(10) << F);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        tf2[j]  <= tf1[j];
        t3_2[j] <= cube2[j][2*F-1:F];
        p2[j]   <= p2c[j];
      end
      zi2 <= ti1[2];
      aa2 <= perm(a1 + ti1[1]);
      ab2 <= perm(a1 + ti1[1] + 8'd1);
      ba2 <= perm(b1 + ti1[1]);
      bb2 <= perm(b1 + ti1[1] + 8'd1);
    end
  end

  logic [2*F+3:0] fp3  [3];
  logic [F+3:0]   fs3  [3];
  perm_t          base3 [4];
  logic [F-1:0]   tf3 [3];
  logic [F:0]     fd3 [3];
  logic [3:0]     h3  [8];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      fp3[j] = (2*F+4)'(t3_2[j]) * (2*F+4)'(p2[j]);
      fs3[j] = fp3[j][2*F+3:F];
    end
    base3[0] = aa2;
    base3[1] = ba2;
    base3[2] = ab2;
    base3[3] = bb2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        tf3[j] <= tf2[j];
        fd3[j] <= (fs3[j] > (F+4)'(ONE)) ? ONE : fs3[j][F:0];
      end
      for (int c = 0; c < 8; c++) begin
        h3[c] <= 4'(perm(base3[c % 4] + zi2 + 8'(c / 4)));
      end
    end
  end

  logic signed [GW-1:0] g4c [8];
  logic signed [GW-1:0] g4  [8];
  logic [F:0]           fd4 [3];
  logic signed [GW-1:0] cx4, cy4, cz4;

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      cx4 = $signed(GW'(tf3[0])) - (c % 2 == 1 ? $signed(GW'(ONE)) : '0);
      cy4 = $signed(GW'(tf3[1])) - ((c / 2) % 2 == 1 ? $signed(GW'(ONE)) : '0);
      cz4 = $signed(GW'(tf3[2])) - (c / 4 == 1 ? $signed(GW'(ONE)) : '0);
      g4c[c] = grad(h3[c], cx4, cy4, cz4);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g4  <= g4c;
      fd4 <= fd3;
    end
  end

  logic signed [GW-1:0] lx5 [4];
  logic [F:0]           fv5, fw5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        lx5[k] <= lerp(g4[2*k], g4[2*k+1], fd4[0]);
      end
      fv5 <= fd4[1];
      fw5 <= fd4[2];
    end
  end

  logic signed [GW-1:0] ly6 [2];
  logic [F:0]           fw6;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < 2; m++) begin
        ly6[m] <= lerp(lx5[2*m], lx5[2*m+1], fv5);
      end
      fw6 <= fw5;
    end
  end

  logic signed [GW-1:0] n7;

  always_ff @(posedge clk) begin
    if (en) begin
      n7 <= lerp(ly6[0], ly6[1], fw6);
    end
  end

  logic signed [GW:0] s8c;
  logic signed [GW:0] h8c;
  logic [F:0]         val8;

  always_comb begin
    s8c = {n7[GW-1], n7} + $signed((GW+1)'(ONE));
    h8c = s8c >>> 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (h8c < 0) begin
        val8 <= '0;
      end else if (h8c > $signed((GW+1)'(ONE))) begin
        val8 <= ONE;
      end else begin
        val8 <= h8c[F:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_prod <= (F+AMP_W+1)'(val8) * (F+AMP_W+1)'(ampq[NS-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= NS; s++) begin
        vq[s] <= 1'b0;
      end
    end else if (en) begin
      vq[1] <= in_valid;
      for (int s = 2; s <= NS; s++) begin
        vq[s] <= vq[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ampq[1]  <= in_amp;
      lastq[1] <= in_last;
      for (int s = 2; s <= NS; s++) begin
        ampq[s]  <= ampq[s-1];
        lastq[s] <= lastq[s-1];
      end
    end
  end

  assign out_valid = vq[NS];
  assign out_amp   = ampq[NS];
  assign out_last  = lastq[NS];

endmodule
`default_nettype wire

// ===== sv/fractal_perlin_noise_3d_unit.sv =====
`default_nettype none
// Channel   Direction  Handshake                  Payload
// s_*       in         s_tvalid / s_tready        s_tdata: coord_x, coord_y, coord_z
// m_*       out        m_tvalid / m_tready        m_tdata: noise_value
// cfg_*     in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// An item holds the octave issue slot for octave_count octaves (clamped to 1 to
// MAX_OCTAVES), one octave per cycle unless the output stalls, into the shared
// nine-stage noise pipeline, then the accumulator sum is loaded into an 18-register
// divider (load plus 17 quotient steps), followed by the output register.
// Reset restores the register defaults and clears all valid bits.
// A result not taken at the output register holds every stage in place.
module fractal_perlin_noise_3d_unit import fpn_pkg::*; #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,   // coord_x, coord_y, coord_z
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // noise_value
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  localparam int F    = FRAC_BITS;
  localparam int AW   = 17;
  localparam int OW   = $clog2(MAX_OCTAVES + 1);
  localparam int PW   = F + AW + 1;
  localparam int LW   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int TW   = PW + LW;
  localparam int WW   = AW + LW;
  localparam int NW   = TW + 16;
  localparam int DW   = WW + F;
  localparam int QB   = 17;
  localparam int RW   = (NW > DW + QB) ? NW : DW + QB;

  logic [3:0]  octave_count;
  logic [16:0] persistence;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= OCTAVE_COUNT_RESET;
      persistence  <= PERSISTENCE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_OCTAVE_COUNT) begin
        octave_count <= cfg_data[3:0];
      end else if (cfg_index == CFG_PERSISTENCE) begin
        persistence <= cfg_data;
      end
    end
  end

  logic adv;
  assign adv = !m_tvalid || m_tready;

  logic          busy;
  logic [OW-1:0] rem;
  logic [31:0]   cx, cy, cz;
  logic [AW-1:0] amp;
  logic [OW-1:0] oct_clamped;
  logic [AW-1:0] pers_clamped;
  logic [2*AW-1:0] amp_prod;
  logic          issue_last;
  logic          accept;

  always_comb begin
    if (octave_count == 4'd0) begin
      oct_clamped = OW'(1);
    end else if (32'(octave_count) > MAX_OCTAVES) begin
      oct_clamped = OW'(MAX_OCTAVES);
    end else begin
      oct_clamped = OW'(octave_count);
    end
    pers_clamped = (persistence > AMP_ONE) ? AMP_ONE : persistence;
    amp_prod     = (2*AW)'(amp) * (2*AW)'(pers_clamped);
  end

  assign issue_last = (rem == OW'(1));
  assign s_tready   = adv && (!busy || issue_last);
  assign accept     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rem  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      rem  <= oct_clamped;
    end else if (busy && adv) begin
      busy <= !issue_last;
      rem  <= rem - OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cx  <= s_tdata[31:0];
      cy  <= s_tdata[63:32];
      cz  <= s_tdata[95:64];
      amp <= AMP_ONE;
    end else if (busy && adv) begin
      cx  <= cx << 1;
      cy  <= cy << 1;
      cz  <= cz << 1;
      amp <= amp_prod[AW+15:16];
    end
  end

  logic          core_valid;
  logic [PW-1:0] core_prod;
  logic [AW-1:0] core_amp;
  logic          core_last;

  fpn_core #(
    .FRAC_BITS(FRAC_BITS),
    .AMP_W(AW)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .en(adv),
    .in_valid(busy),
    .in_x(cx),
    .in_y(cy),
    .in_z(cz),
    .in_amp(amp),
    .in_last(issue_last),
    .out_valid(core_valid),
    .out_prod(core_prod),
    .out_amp(core_amp),
    .out_last(core_last)
  );

  logic          acc_open;
  logic [TW-1:0] acc_tot;
  logic [WW-1:0] acc_ws;
  logic [TW-1:0] tot_sum;
  logic [WW-1:0] ws_sum;

  assign tot_sum = (acc_open ? acc_tot : '0) + TW'(core_prod);
  assign ws_sum  = (acc_open ? acc_ws : '0) + WW'(core_amp);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_open <= 1'b0;
    end else if (adv && core_valid) begin
      acc_open <= !core_last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && core_valid) begin
      acc_tot <= tot_sum;
      acc_ws  <= ws_sum;
    end
  end

  logic          dv [0:QB];
  logic [RW-1:0] rr [0:QB];
  logic [DW-1:0] dd [0:QB];
  logic [QB-1:0] qq [0:QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= QB; s++) begin
        dv[s] <= 1'b0;
      end
    end else if (adv) begin
      dv[0] <= core_valid && core_last;
      for (int s = 1; s <= QB; s++) begin
        dv[s] <= dv[s-1];
      end
    end
  end

  logic [RW-1:0] dsh [QB];

  always_comb begin
    for (int s = 0; s < QB; s++) begin
      dsh[s] = RW'(dd[s]) << (QB - 1 - s);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rr[0] <= RW'({tot_sum, 16'd0});
      dd[0] <= {ws_sum, {F{1'b0}}};
      qq[0] <= '0;
      for (int s = 0; s < QB; s++) begin
        dd[s+1] <= dd[s];
        if (rr[s] >= dsh[s]) begin
          rr[s+1] <= rr[s] - dsh[s];
          qq[s+1] <= qq[s] | (QB'(1) << (QB - 1 - s));
        end else begin
          rr[s+1] <= rr[s];
          qq[s+1] <= qq[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= qq[QB][QB-1] ? NOISE_MAX : qq[QB][15:0];
    end
  end

  assert property (@(posedge clk) disable iff (rst) busy |-> rem != '0)
    else $error("octave issuer busy with no octaves left");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(acc_tot) && $stable(acc_open) && $stable(rem)))
    else $error("pipeline moved while the output was stalled");

  assert property (@(posedge clk) disable iff (rst) dv[0] |-> dd[0] != '0)
    else $error("divider started with a zero weight sum");

  assert property (@(posedge clk) disable iff (rst)
    (core_valid && core_last && adv) |=> !acc_open)
    else $error("accumulator left open after the last octave");

endmodule
`default_nettype wire

// ===== tb/fractal_perlin_noise_3d_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module fractal_perlin_noise_3d_unit_tb import fpn_pkg::*; ();

  localparam int FRAC = 16;
  localparam int OCT_MAX = 8;
  localparam int ONE = 1 << FRAC;

  class noise_scoreboard;
    logic [15:0] pending[$];
    int errors;
    int checked;

    function void note_sample(logic [15:0] v);
      pending.push_back(v);
    endfunction

    function bit check_result(logic [15:0] got, output logic [15:0] want);
      want = 'x;
      if (pending.size() == 0) begin
        errors++;
        return 0;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [95:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [15:0] m_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  noise_scoreboard board;
  int mismatches = 0;
  logic [3:0] octave_reg;
  logic [16:0] persist_reg;
  bit hold_off = 0;
  bit idle_free = 0;
  int sent = 0;
  int cfg_writes = 0;

  fractal_perlin_noise_3d_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint floor_div_pow2(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic longint fade_curve(longint t);
    longint t2, t3, p, f;
    t2 = (t * t) >> FRAC;
    t3 = (t2 * t) >> FRAC;
    p = 6 * t2 - 15 * t + 10 * ONE;
    if (p < 0) p = 0;
    f = (t3 * p) >> FRAC;
    if (f > ONE) f = ONE;
    return f;
  endfunction

  function automatic longint grad_dot(logic [7:0] h, longint x, longint y, longint z);
    case (h[3:0])
      4'h0: return x + y;
      4'h1: return -x + y;
      4'h2: return x - y;
      4'h3: return -x - y;
      4'h4: return x + z;
      4'h5: return -x + z;
      4'h6: return x - z;
      4'h7: return -x - z;
      4'h8: return y + z;
      4'h9: return -y + z;
      4'hA: return y - z;
      4'hB: return -y - z;
      4'hC: return y + x;
      4'hD: return -y + z;
      4'hE: return y - x;
      default: return -y - z;
    endcase
  endfunction

  function automatic longint blend(longint a, longint b, longint s);
    return a + floor_div_pow2(s * (b - a), FRAC);
  endfunction

  function automatic logic [7:0] hashed(logic [7:0] idx);
    return PERM_ROM[idx];
  endfunction

  function automatic longint octave_noise(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
    logic [7:0] xi, yi, zi, a, b, aa, ab, ba, bb;
    longint xf, yf, zf, u, v, w, x1, x2, y1, y2, n, val;
    xi = cx[FRAC+7:FRAC];
    yi = cy[FRAC+7:FRAC];
    zi = cz[FRAC+7:FRAC];
    xf = cx[FRAC-1:0];
    yf = cy[FRAC-1:0];
    zf = cz[FRAC-1:0];
    u = fade_curve(xf);
    v = fade_curve(yf);
    w = fade_curve(zf);
    a = hashed(xi);
    b = hashed(xi + 8'd1);
    aa = hashed(a + yi);
    ab = hashed(a + yi + 8'd1);
    ba = hashed(b + yi);
    bb = hashed(b + yi + 8'd1);
    x1 = blend(grad_dot(hashed(aa + zi), xf, yf, zf),
               grad_dot(hashed(ba + zi), xf - ONE, yf, zf), u);
    x2 = blend(grad_dot(hashed(ab + zi), xf, yf - ONE, zf),
               grad_dot(hashed(bb + zi), xf - ONE, yf - ONE, zf), u);
    y1 = blend(x1, x2, v);
    x1 = blend(grad_dot(hashed(aa + zi + 8'd1), xf, yf, zf - ONE),
               grad_dot(hashed(ba + zi + 8'd1), xf - ONE, yf, zf - ONE), u);
    x2 = blend(grad_dot(hashed(ab + zi + 8'd1), xf, yf - ONE, zf - ONE),
               grad_dot(hashed(bb + zi + 8'd1), xf - ONE, yf - ONE, zf - ONE), u);
    y2 = blend(x1, x2, v);
    n = blend(y1, y2, w);
    val = floor_div_pow2(n + ONE, 1);
    if (val < 0) val = 0;
    if (val > ONE) val = ONE;
    return val;
  endfunction

  function automatic logic [15:0] fbm_noise(logic [31:0] cx, logic [31:0] cy,
                                            logic [31:0] cz);
    int oct;
    longint unsigned pers, amp, total, wsum, res;
    oct = octave_reg;
    pers = persist_reg;
    amp = 65536;
    total = 0;
    wsum = 0;
    if (oct == 0) oct = 1;
    if (oct > OCT_MAX) oct = OCT_MAX;
    if (pers > 65536) pers = 65536;
    for (int i = 0; i < oct; i++) begin
      total += longint'(octave_noise(cx << i, cy << i, cz << i)) * amp;
      wsum += amp;
      amp = (amp * pers) >> 16;
    end
    res = (total << 16) / (wsum << FRAC);
    if (res > 65535) res = 65535;
    return res[15:0];
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("ERROR %0t: %s noise_value got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic write_register(logic [3:0] idx, logic [16:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_OCTAVE_COUNT) octave_reg = val[3:0];
    else if (idx == CFG_PERSISTENCE) persist_reg = val;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_sample(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    @(negedge clk);
    while (!idle_free && $urandom_range(99) < 10) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_sample(fbm_noise(x, y, z));
    sent++;
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    @(negedge clk);
    s_tvalid <= 0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return {{16{1'b0}}, 16'($urandom())} + ($urandom_range(7) << 16);
      default: return {$urandom_range(255) << 16} | $urandom_range(65535);
    endcase
  endfunction

  initial begin
    logic [15:0] want;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (!board.check_result(m_tdata, want)) report_mismatch("output", m_tdata, want);
      end
    end
  end

  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        m_tready <= 0;
        stall = 0;
        while (stall < 400) begin
          @(negedge clk);
          stall++;
        end
        hold_off = 0;
      end
      m_tready <= idle_free || ($urandom_range(99) >= 10);
      @(negedge clk);
    end
  end

  initial begin
    #20ms;
    $display("fractal_perlin_noise_3d_unit: mismatch");
    $finish;
  end

  initial begin
    logic [31:0] edge_vals[8];
    logic [3:0] octs[6];
    logic [16:0] pers_set[6];
    board = new();
    octave_reg = OCTAVE_COUNT_RESET;
    persist_reg = PERSISTENCE_RESET;
    edge_vals = '{32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                  32'h0000FFFF, 32'h00FF0000, 32'h00010000, 32'hAAAA5555};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed corners at reset settings, then octave and persistence extremes.
    for (int i = 0; i < 8; i++)
      send_sample(edge_vals[i], edge_vals[(i + 3) % 8], edge_vals[(i + 5) % 8]);
    drain();
    write_register(CFG_OCTAVE_COUNT, 17'd0);
    write_register(CFG_PERSISTENCE, 17'h1FFFF);
    for (int i = 0; i < 4; i++) send_sample(edge_vals[i], edge_vals[i + 4], $urandom());
    drain();
    write_register(CFG_OCTAVE_COUNT, 17'd15);
    write_register(CFG_PERSISTENCE, AMP_ONE);
    for (int i = 0; i < 4; i++) send_sample(edge_vals[7 - i], $urandom(), edge_vals[i]);
    drain();
    write_register(CFG_PERSISTENCE, 17'd0);
    for (int i = 0; i < 4; i++) send_sample($urandom(), edge_vals[i * 2], edge_vals[i]);
    drain();

    octs = '{4'd1, 4'd8, 4'd0, 4'd3, 4'd12, 4'd5};
    pers_set = '{17'd32768, 17'd65536, 17'd0, 17'd1, 17'h1FFFF, 17'd45000};
    for (int ph = 0; ph < 6; ph++) begin
      write_register(CFG_OCTAVE_COUNT, {13'd0, octs[ph]});
      write_register(CFG_PERSISTENCE, ph == 5 ? 17'($urandom()) : pers_set[ph]);
      idle_free = (ph == 2);
      if (ph == 3) hold_off = 1;
      for (int k = 0; k < 165; k++)
        send_sample(rand_coord(k % 3), rand_coord((k + 1) % 3), rand_coord($urandom_range(2)));
      drain();
    end
    idle_free = 0;
    drain();
    $display("Covered %0d samples over %0d register writes, octaves 0..15 and persistence",
             sent, cfg_writes);
    $display("from zero to above one, with output back-pressure and input idling.");
    if (mismatches == 0 && board.errors == 0 && board.pending.size() == 0)
      $display("fractal_perlin_noise_3d_unit: match");
    else
      $display("fractal_perlin_noise_3d_unit: mismatch");
    $finish;
  end
endmodule
